// File: design/swa_pkg.sv
package swa_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned FilledW  = 5;
  localparam int unsigned WindowDef = 16;

  // controller to datapath
  typedef struct packed {
    logic load_in;    // capture sample, read oldest entry
    logic update;     // write entry, update sum, count and position
    logic div_start;  // load divider with |sum|
    logic div_step;   // one quotient bit
    logic out_load;   // move signed quotient into output register
  } swa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;   // current step is the final one
    logic out_free;   // output register can take a new result
  } swa_sts_t;

endpackage

// File: design/swa_in_if.sv
interface swa_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [swa_pkg::SampleW-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// File: design/swa_out_if.sv
interface swa_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [swa_pkg::SampleW-1:0]  mean;
  logic        [swa_pkg::FilledW-1:0]  filled;

  modport source (output valid, output mean, output filled, input ready);
  modport sink   (input valid, input mean, input filled, output ready);
endinterface

// File: design/swa_ctrl.sv
module swa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  swa_pkg::swa_sts_t sts_i,
  output swa_pkg::swa_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPDATE = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_DSTART;
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_FINISH;
      end
      S_FINISH: begin
        // hold the result until the output register drains
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded over a pending result");

  a_step_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> cmd_o.div_step)
    else $error("divider started without stepping");

endmodule

// File: design/swa_datapath.sv
module swa_datapath #(
  parameter int unsigned WINDOW = swa_pkg::WindowDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  swa_pkg::swa_cmd_t                  cmd_i,
  output swa_pkg::swa_sts_t                  sts_o,
  input  logic signed [swa_pkg::SampleW-1:0] sample_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [swa_pkg::SampleW-1:0] mean_o,
  output logic        [swa_pkg::FilledW-1:0] filled_o
);

  localparam int unsigned SW = swa_pkg::SampleW;
  localparam int unsigned PW = $clog2(WINDOW);
  localparam int unsigned FW = $clog2(WINDOW + 1);
  localparam int unsigned UW = SW + $clog2(WINDOW);   // sum width
  localparam int unsigned CW = $clog2(UW + 1);

  logic signed [SW-1:0] mem_q [WINDOW];
  logic signed [SW-1:0] sample_q, old_q;
  logic        [PW-1:0] pos_q;
  logic        [FW-1:0] fill_q;
  logic signed [UW-1:0] sum_q, sum_d;
  logic        [FW:0]   rem_q;
  logic        [UW-1:0] quo_q;
  logic                 neg_q;
  logic        [CW-1:0] cnt_q;
  logic signed [SW-1:0] mean_q;
  logic [swa_pkg::FilledW-1:0] filled_q;
  logic                 out_valid_q;

  logic          full;
  logic [FW:0]   shifted, divisor;
  logic          ge;
  logic [SW-1:0] quo_low;

  assign full    = (fill_q == FW'(WINDOW));
  assign sum_d   = sum_q + UW'(sample_q) - (full ? UW'(old_q) : UW'(0));
  assign shifted = {rem_q[FW-1:0], quo_q[UW-1]};
  assign divisor = {1'b0, fill_q};
  assign ge      = (shifted >= divisor);
  assign quo_low = quo_q[SW-1:0];

  assign sts_o.div_last = (cnt_q == CW'(1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // window memory: registered read of the oldest entry, write on update
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) old_q <= mem_q[pos_q];
    if (cmd_i.update)  mem_q[pos_q] <= sample_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) sample_q <= sample_i;
    if (cmd_i.div_start) begin
      quo_q <= sum_q[UW-1] ? UW'(-sum_q) : UW'(sum_q);
      neg_q <= sum_q[UW-1];
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? (shifted - divisor) : shifted;
      quo_q <= {quo_q[UW-2:0], ge};
    end
    if (cmd_i.out_load) begin
      mean_q   <= neg_q ? (-quo_low) : quo_low;
      filled_q <= swa_pkg::FilledW'(fill_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.update) begin
        sum_q  <= sum_d;
        fill_q <= full ? fill_q : fill_q + FW'(1);
        pos_q  <= (pos_q == PW'(WINDOW - 1)) ? '0 : pos_q + PW'(1);
      end
      if (cmd_i.div_start)     cnt_q <= CW'(UW);
      else if (cmd_i.div_step) cnt_q <= cnt_q - CW'(1);
      if (cmd_i.out_load)                    out_valid_q <= 1'b1;
      else if (out_ready_i && out_valid_q)   out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mean_o      = mean_q;
  assign filled_o    = filled_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(WINDOW))
    else $error("fill count beyond window");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(WINDOW - 1))
    else $error("write position beyond window");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (cnt_q == '0) && (fill_q != '0))
    else $error("result taken before division finished");

endmodule

// File: design/sliding_window_average_unit.sv
// channel  modport  payload               meaning
// in_i     sink     sample[15:0] signed   new sample
// out_o    source   mean[15:0] signed     truncated mean of filled entries
//                   filled[4:0]           entries averaged
//
// A result passes these steps from the accepting edge: memory read and sample capture
// at acceptance, the sum update, the divider load, a restoring divide of the W-bit
// |sum| by the fill count, W = 16 + clog2(WINDOW) (W = 20 at WINDOW 16), and the
// load of the output register, which waits while out_o holds an untaken result.
// in_i is ready again right after the load.
// in_i is ready only while no item is in flight; a result waiting on out_o
// does not block acceptance, only the next result load.
// Reset clears count, position, sum and output valid; window entries are
// not cleared, and an entry read before it is written is not used.
module sliding_window_average_unit #(
  parameter int unsigned WINDOW = swa_pkg::WindowDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  swa_in_if.sink    in_i,
  swa_out_if.source out_o
);

  swa_pkg::swa_cmd_t cmd;
  swa_pkg::swa_sts_t sts;

  swa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  swa_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (in_i.sample),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .mean_o      (out_o.mean),
    .filled_o    (out_o.filled)
  );

endmodule

// File: verif/tb_sliding_window_average_unit.sv
`timescale 1ns / 100ps

module tb_sliding_window_average_unit;

  localparam int unsigned Window = swa_pkg::WindowDef;

  typedef struct packed {
    logic signed [swa_pkg::SampleW-1:0] mean;
    logic        [swa_pkg::FilledW-1:0] filled;
  } avg_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  swa_in_if  in_bus ();
  swa_out_if out_bus ();

  sliding_window_average_unit #(
    .WINDOW(Window)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic signed [swa_pkg::SampleW-1:0] win_mem [Window];
  int                        wr_idx   = 0;
  int                        fill_cnt = 0;
  int                        win_sum  = 0;

  logic signed [swa_pkg::SampleW-1:0] sample_q [$];
  avg_result_t               mean_q   [$];

  int  err_cnt     = 0;
  int  results_got = 0;
  int  gap_left    = 0;
  int  stall_left  = 0;
  int  hold_left   = 0;
  bit  hold_done   = 1'b0;
  bit  quiet_tail  = 1'b0;

  function automatic avg_result_t advance_window(
    input logic signed [swa_pkg::SampleW-1:0] s
  );
    avg_result_t r;
    int          q;
    if (fill_cnt >= Window) begin
      win_sum = win_sum - win_mem[wr_idx];
    end else begin
      fill_cnt++;
    end
    win_mem[wr_idx] = s;
    win_sum = win_sum + s;
    wr_idx = (wr_idx + 1) % Window;
    q = win_sum / fill_cnt;
    r.mean   = q[swa_pkg::SampleW-1:0];
    r.filled = fill_cnt[swa_pkg::FilledW-1:0];
    return r;
  endfunction

  // driver: hold valid until the transaction completes
  always @(posedge clk_i) begin
    logic fire;
    logic nxt_valid;
    fire = in_bus.valid && in_bus.ready;
    if (rst_ni) begin
      if (fire) begin
        mean_q.push_back(advance_window(in_bus.sample));
        void'(sample_q.pop_front());
      end
      if (!(in_bus.valid && !fire)) begin
        nxt_valid = 1'b0;
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(0, 8);
        end else if (sample_q.size() != 0) begin
          nxt_valid = 1'b1;
          in_bus.sample <= sample_q[0];
        end
        in_bus.valid <= nxt_valid;
      end
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk_i) begin
    avg_result_t exp_r;
    logic        nxt_ready;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        results_got <= results_got + 1;
        if (mean_q.size() == 0) begin
          $display("%0t: result expected none got mean %0d filled %0d", $time,
                   out_bus.mean, out_bus.filled);
          err_cnt++;
        end else begin
          exp_r = mean_q.pop_front();
          if (out_bus.mean !== exp_r.mean) begin
            $display("%0t: mean expected %0d got %0d", $time, exp_r.mean, out_bus.mean);
            err_cnt++;
          end
          if (out_bus.filled !== exp_r.filled) begin
            $display("%0t: filled expected %0d got %0d", $time, exp_r.filled,
                     out_bus.filled);
            err_cnt++;
          end
        end
      end
      nxt_ready = 1'b0;
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 8);
      end else begin
        nxt_ready = 1'b1;
      end
      out_bus.ready <= nxt_ready && (hold_left == 0);
    end
  end

  // long receiver hold-off: let the block back up into its input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && results_got == 40) begin
        hold_left <= 300;
        hold_done <= 1'b1;
      end
    end
  end

  task automatic push_random(input int n);
    logic signed [swa_pkg::SampleW-1:0] s;
    logic [31:0]               r;
    for (int i = 0; i < n; i++) begin
      r = $urandom();
      case ($urandom_range(0, 9))
        0:       s = r[0] ? 16'sh7fff : 16'sh8000;
        1, 2:    s = $signed(16'($urandom_range(0, 15))) - 16'sd8;
        default: s = r[swa_pkg::SampleW-1:0];
      endcase
      sample_q.push_back(s);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || mean_q.size() != 0);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.sample  = '0;
    out_bus.ready  = 1'b0;

    // extremes, truncation of a small negative sum, then fill and wrap
    sample_q.push_back(16'sh7fff);
    sample_q.push_back(16'sh8000);
    sample_q.push_back(-16'sd1);
    sample_q.push_back(16'sd1);
    sample_q.push_back(16'sd0);
    repeat (16) sample_q.push_back(16'sh8000);
    repeat (4) sample_q.push_back(16'sh7fff);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait_drained();
    push_random(300);
    // sender pauses until every result is back
    wait_drained();
    push_random(450);
    wait_drained();
    quiet_tail = 1'b1;
    push_random(50);
    wait_drained();

    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("** sliding_window_average_unit: PASSED **");
    end else begin
      $display("** sliding_window_average_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("** sliding_window_average_unit: FAILED **");
    $finish;
  end

endmodule
